FILE: rtl/core/positional_list_engine_macros.svh
// Assertion macros for the positional list engine.
// Used by the top level; expects clk and arst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check a property on every clock edge out of reset.
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; every other file but the macros header imports it.
package ple_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KIND_W       = 2;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 10;
	localparam int STATUS_W     = 2;
	localparam int LEN_W        = 7;
	localparam int GROUP_W      = 32;

	typedef enum logic [KIND_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NOP    = 2'd3
	} op_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DONE
	} state_t;

	// Broadcast command to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic remove;
		logic probe;
	} cell_cmd_t;

	// Match sweep status back to the controller.
	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

FILE: rtl/core/ple_cmd_if.sv
// Command channel: operation kind, value and insert position.
// Depends on ple_pkg for field widths.
interface ple_cmd_if
	import ple_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

FILE: rtl/core/ple_rsp_if.sv
// Response channel: status, search hit and list length.
// Depends on ple_pkg for field widths.
interface ple_rsp_if
	import ple_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [LEN_W-1:0]    length;

	modport source (output valid, status, found, length, input ready);
	modport sink   (input valid, status, found, length, output ready);
endinterface

FILE: rtl/core/ple_cell.sv
// One list cell: holds an entry, shifts to and from its neighbors,
// and flags a key match. Depends on ple_pkg.
module ple_cell
	import ple_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX      = 0,
	localparam int IW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [IW-1:0]      ins_at,
	input  logic [CW-1:0]      count,
	input  logic [VALUE_W-1:0] key,
	input  logic [VALUE_W-1:0] left_data,
	input  logic [VALUE_W-1:0] right_data,
	output logic [VALUE_W-1:0] data_q,
	output logic               match_q
);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	// Shift up above the insert point, load at it, shift down on remove.
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (MY_IDX > ins_at) begin
				data_q <= left_data;
			end else if (MY_IDX == ins_at) begin
				data_q <= key;
			end
		end else if (cmd.remove) begin
			data_q <= right_data;
		end
	end

	// Flag a match only for a held entry.
	always_ff @(posedge clk) begin
		if (cmd.probe) begin
			match_q <= (data_q == key) && (MY_POS < count);
		end
	end
endmodule

FILE: rtl/core/ple_scan.sv
// Match sweep: ORs the cell match flags one 32-bit group per cycle.
// Depends on ple_pkg.
module ple_scan
	import ple_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CAPACITY-1:0] match_vec,
	output scan_stat_t          stat
);
	localparam int NG  = (CAPACITY + GROUP_W - 1) / GROUP_W;
	localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
	localparam int NGP = 2 ** GIW;
	localparam logic [GIW-1:0] LAST = GIW'(NG - 1);

	logic [NGP*GROUP_W-1:0] padded;
	logic [GIW-1:0]         grp_q;
	logic                   run_q;
	logic                   done_q;
	logic                   acc_q;
	logic                   hit_q;
	logic                   grp_any;

	assign padded  = (NGP*GROUP_W)'(match_vec);
	assign grp_any = |padded[grp_q*GROUP_W +: GROUP_W];

	// Advance through the groups, accumulate, pulse done after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			grp_q  <= '0;
			acc_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				grp_q <= '0;
				acc_q <= 1'b0;
			end else if (run_q) begin
				acc_q <= acc_q | grp_any;
				if (grp_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					grp_q <= grp_q + 1'b1;
				end
			end
		end
	end

	// Hold the final hit for the controller.
	always_ff @(posedge clk) begin
		if (run_q && grp_q == LAST) begin
			hit_q <= acc_q | grp_any;
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign stat.hit  = hit_q;
endmodule

FILE: rtl/core/positional_list_engine.sv
// Top level of the positional list engine: controller, cell chain, sweep.
// Depends on ple_pkg, ple_cmd_if, ple_rsp_if, ple_cell, ple_scan, macros.
//
//  channel | dir | payload                      | accepted when
//  cmd     | in  | kind, value, position        | cmd.valid && cmd.ready
//  rsp     | out | status, found, length        | rsp.valid && rsp.ready
//
// Insert, remove and the unused kind go from accept to an execute state, where
// for insert and remove the whole cell chain shifts at once, then to result load.
// Search adds a match sweep that ORs
// one 32-bit group of cell flags per cycle. Reset clears the entry count and
// control; entries need no clearing. A stalled response holds in its output
// register while the next item is accepted and worked on.
`include "positional_list_engine_macros.svh"

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_cmd_if.sink   cmd,
	ple_rsp_if.source rsp
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CW > POS_W) ? CW : POS_W;
	localparam int EW = (CW > LEN_W) ? CW : LEN_W;
	localparam logic [CW-1:0] FULL = CW'(CAPACITY);

	state_t              state_q, state_d;
	op_kind_t            kind_q;
	logic [VALUE_W-1:0]  value_q;
	logic [POS_W-1:0]    pos_q;
	logic [CW-1:0]       count_q;
	status_code_t        status_q;
	logic                found_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                rsp_found_q;
	logic [LEN_W-1:0]    rsp_length_q;

	cell_cmd_t           cell_cmd;
	scan_stat_t          scan_stat;
	logic                scan_start;
	logic                is_full;
	logic                is_empty;
	logic [AW-1:0]       pos_ext;
	logic [AW-1:0]       cnt_ext;
	logic [AW-1:0]       at_raw;
	logic [AW-1:0]       at_clip;
	logic [IW-1:0]       ins_at;
	logic [EW-1:0]       len_ext;
	logic                rsp_free;
	logic                cmd_take;

	logic [VALUE_W-1:0]  cell_data [CAPACITY];
	logic [CAPACITY-1:0] match_vec;

	assign is_full  = (count_q == FULL);
	assign is_empty = (count_q == '0);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign cmd_take = cmd.valid && cmd.ready;

	// Insert index: front for position at most one, clip to the count.
	assign pos_ext = AW'(pos_q);
	assign cnt_ext = AW'(count_q);
	assign at_raw  = (pos_ext <= AW'(1)) ? '0 : pos_ext - AW'(1);
	assign at_clip = (at_raw > cnt_ext) ? cnt_ext : at_raw;
	assign ins_at  = at_clip[IW-1:0];

	// Hold the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one item: execute, sweep for a search, then deliver.
	always_comb begin
		state_d    = state_q;
		cell_cmd   = '0;
		scan_start = 1'b0;
		cmd.ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (kind_q)
					OP_INSERT: begin
						cell_cmd.insert = !is_full;
						state_d         = S_DONE;
					end
					OP_REMOVE: begin
						cell_cmd.remove = !is_empty;
						state_d         = S_DONE;
					end
					OP_SEARCH: begin
						cell_cmd.probe = 1'b1;
						scan_start     = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (scan_stat.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			kind_q  <= op_kind_t'(cmd.kind);
			value_q <= cmd.value;
			pos_q   <= cmd.position;
		end
	end

	// Update the entry count on insert and remove.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cell_cmd.insert) begin
			count_q <= count_q + 1'b1;
		end else if (cell_cmd.remove) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Record status and hit for the pending result.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			found_q <= 1'b0;
			if (kind_q == OP_INSERT && is_full) begin
				status_q <= ST_FULL;
			end else if (kind_q == OP_REMOVE && is_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
		end else if (state_q == S_SCAN && scan_stat.done) begin
			found_q <= scan_stat.hit;
		end
	end

	assign len_ext = EW'(count_q);

	// Load the response register; drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_length_q <= len_ext[LEN_W-1:0];
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.found  = rsp_found_q;
	assign rsp.length = rsp_length_q;

	// Build the cell chain; each cell sees its neighbors' data, the first the new value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_d;
		logic [VALUE_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = value_q;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_body
			assign right_d = cell_data[i+1];
		end

		ple_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.ins_at     (ins_at),
			.count      (count_q),
			.key        (value_q),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[i]),
			.match_q    (match_vec[i])
		);
	end

	ple_scan #(
		.CAPACITY (CAPACITY)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.match_vec (match_vec),
		.stat      (scan_stat)
	);

	`PLE_ASSERT_ALWAYS(a_count_bound, count_q <= FULL, "entry count above capacity")
	`PLE_ASSERT(a_insert_grows, cell_cmd.insert |=> count_q == $past(count_q) + 1'b1, "insert did not grow list")
	`PLE_ASSERT(a_scan_in_search, scan_stat.busy |-> state_q == S_SCAN, "sweep running outside a search")
	`PLE_ASSERT(a_take_execs, cmd_take |=> state_q == S_EXEC, "accepted item not executed")
endmodule

FILE: sim/tb_positional_list_engine.sv
// Self-checking testbench for the positional list engine: a short scripted table,
// then random insert/remove/search traffic checked against a built-in list predictor.
// Depends on ple_pkg, ple_cmd_if, ple_rsp_if and the positional_list_engine RTL.
`timescale 1ns / 100ps

module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int N_RANDOM    = 1300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [LEN_W-1:0]    length;
	} list_rsp_t;

	typedef struct {
		op_kind_t                  kind;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
		bit                        typed;
		list_rsp_t                 want;
	} script_row_t;

	logic clk;
	logic arst_n;

	ple_cmd_if cmd_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine #(
		.CAPACITY(CAPACITY_DEF)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// Predicted list contents and the queue of expected responses
	logic signed [VALUE_W-1:0] list_vals [CAPACITY_DEF];
	int                        list_len;
	list_rsp_t                 pending_rsp [$];

	int mismatch_cnt;
	int cycle_cnt;
	bit no_idle;
	bit hold_off_req;

	// Scripted items; typed expectations only where they are obvious
	script_row_t script [0:19] = '{
		'{OP_REMOVE, 32'h00000000, 10'd0,    1'b1, '{ST_EMPTY, 1'b0, 7'd0}},
		'{OP_SEARCH, 32'h00000000, 10'd0,    1'b1, '{ST_DONE,  1'b0, 7'd0}},
		'{OP_NOP,    32'hFFFFFFFF, 10'd1023, 1'b1, '{ST_DONE,  1'b0, 7'd0}},
		'{OP_INSERT, 32'h7FFFFFFF, 10'd0,    1'b1, '{ST_DONE,  1'b0, 7'd1}},
		'{OP_INSERT, 32'h80000000, 10'd1,    1'b1, '{ST_DONE,  1'b0, 7'd2}},
		'{OP_INSERT, 32'hFFFFFFFF, 10'd1023, 1'b1, '{ST_DONE,  1'b0, 7'd3}},
		'{OP_INSERT, 32'h00000000, 10'd2,    1'b1, '{ST_DONE,  1'b0, 7'd4}},
		'{OP_SEARCH, 32'h80000000, 10'd0,    1'b1, '{ST_DONE,  1'b1, 7'd4}},
		'{OP_SEARCH, 32'h7FFFFFFE, 10'd1023, 1'b1, '{ST_DONE,  1'b0, 7'd4}},
		'{OP_SEARCH, 32'hFFFFFFFF, 10'd0,    1'b1, '{ST_DONE,  1'b1, 7'd4}},
		'{OP_NOP,    32'h00000000, 10'd0,    1'b1, '{ST_DONE,  1'b0, 7'd4}},
		'{OP_INSERT, 32'h12345678, 10'd4,    1'b0, '0},
		'{OP_INSERT, -32'sd7,      10'd3,    1'b0, '0},
		'{OP_SEARCH, 32'h12345678, 10'd0,    1'b0, '0},
		'{OP_REMOVE, 32'hFFFFFFFF, 10'd1023, 1'b0, '0},
		'{OP_REMOVE, 32'h00000000, 10'd0,    1'b0, '0},
		'{OP_SEARCH, 32'h80000000, 10'd0,    1'b0, '0},
		'{OP_INSERT, 32'h00000055, 10'd5,    1'b0, '0},
		'{OP_SEARCH, 32'h00000055, 10'd0,    1'b0, '0},
		'{OP_SEARCH, 32'h00000000, 10'd0,    1'b0, '0}
	};

	// Apply one operation to the predicted list and return its response
	function automatic list_rsp_t apply_list_op(input op_kind_t k,
			input logic signed [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
		list_rsp_t r;
		int        at;
		r = '{ST_DONE, 1'b0, '0};
		case (k)
			OP_INSERT: begin
				if (list_len >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					// positions 0 and 1 both mean the front; past the end appends
					at = (p <= 1) ? 0 : int'(p) - 1;
					if (at > list_len)
						at = list_len;
					for (int i = list_len; i > at; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[at] = v;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int i = 1; i < list_len; i++)
						list_vals[i-1] = list_vals[i];
					list_len--;
				end
			end
			OP_SEARCH: begin
				for (int i = 0; i < list_len; i++)
					if (list_vals[i] == v)
						r.found = 1'b1;
			end
			default: ;
		endcase
		r.length = list_len[LEN_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(input string field, input int want, input int got);
		mismatch_cnt++;
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
	endtask

	// Offer one command item, after a random idle gap unless no_idle, and hold it until accepted
	task automatic offer_cmd(input op_kind_t k, input logic signed [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p, input bit typed, input list_rsp_t want);
		int        gap;
		list_rsp_t pred;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.kind     <= k;
		cmd_ch.value    <= v;
		cmd_ch.position <= p;
		do
			@(posedge clk);
		while (!(cmd_ch.valid && cmd_ch.ready));
		pred = apply_list_op(k, v, p);
		pending_rsp.push_back(typed ? want : pred);
	endtask

	// Small values so duplicates and hits are common, extremes, or any random value
	function automatic logic signed [VALUE_W-1:0] draw_value();
		case ($urandom_range(0, 5))
			0:       return 32'h7FFFFFFF;
			1:       return 32'h80000000;
			2, 3:    return $signed($urandom_range(0, 15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Clock, reset and timeout
	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check each accepted response against the oldest expectation
	always @(posedge clk) begin
		list_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				note_mismatch("unexpected response, length", -1, rsp_ch.length);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.status)
					note_mismatch("status", want.status, rsp_ch.status);
				if (rsp_ch.found !== want.found)
					note_mismatch("found", want.found, rsp_ch.found);
				if (rsp_ch.length !== want.length)
					note_mismatch("length", want.length, rsp_ch.length);
			end
		end
	end

	// Response side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (hold_off_req) begin
				stall        = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Stimulus: reset, scripted table, then random fill/drain traffic
	initial begin
		op_kind_t                  k;
		logic signed [VALUE_W-1:0] v;
		logic [POS_W-1:0]          p;
		bit                        filling;
		int                        r;
		mismatch_cnt    = 0;
		no_idle         = 1'b0;
		hold_off_req    = 1'b0;
		list_len        = 0;
		filling         = 1'b1;
		cycle_cnt       <= 0;
		arst_n          <= 1'b0;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.kind     <= OP_NOP;
		cmd_ch.value    <= '0;
		cmd_ch.position <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			offer_cmd(script[i].kind, script[i].value, script[i].position,
				script[i].typed, script[i].want);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n == N_RANDOM / 2)
				hold_off_req = 1'b1;

			// swing between filling toward capacity and draining to empty
			if (list_len == CAPACITY_DEF && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (list_len == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				filling = ~filling;

			r = $urandom_range(0, 99);
			if (r < 3)
				k = OP_NOP;
			else if (r < 25)
				k = OP_SEARCH;
			else if (r < 85)
				k = filling ? OP_INSERT : OP_REMOVE;
			else
				k = filling ? OP_REMOVE : OP_INSERT;

			// search keys often taken from the list so hits occur
			if (k == OP_SEARCH && list_len > 0 && $urandom_range(0, 1) == 0)
				v = list_vals[$urandom_range(0, list_len - 1)];
			else
				v = draw_value();

			case ($urandom_range(0, 4))
				0:       p = POS_W'($urandom_range(0, 1));
				1:       p = POS_W'($urandom);
				2:       p = POS_W'(list_len + $urandom_range(1, 3));
				default: p = POS_W'($urandom_range(0, list_len + 1));
			endcase

			offer_cmd(k, v, p, 1'b0, '0);
		end
		cmd_ch.valid <= 1'b0;

		// drain, then allow for any late response
		wait (pending_rsp.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_cnt == 0 && pending_rsp.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
